[design/md5_pkg.sv]
package md5_pkg;

    localparam logic [1:0] MODE_ABSORB        = 2'd0;
    localparam logic [1:0] MODE_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] MODE_FINISH        = 2'd2;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // queue entry between the front and back parts
    typedef struct packed {
        logic       has_byte;
        logic       finish;
        logic [7:0] data;
    } t_cmd;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] r);
        logic [4:0] s;
        begin
            case ({r[5:4], r[1:0]})
                4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    function automatic logic [3:0] round_g(input logic [5:0] r);
        logic [3:0] g;
        logic [3:0] lo;
        begin
            lo = r[3:0];
            case (r[5:4])
                2'd0:    g = lo;
                2'd1:    g = 4'((lo << 2) + lo + 4'd1);
                2'd2:    g = 4'((lo << 1) + lo + 4'd5);
                default: g = 4'((lo << 3) - lo);
            endcase
            return g;
        end
    endfunction

endpackage

[design/md5_ram.sv]
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/md5_front.sv]
module md5_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_mode,
    input  logic [7:0]     i_data_byte,
    output logic           o_cmd_valid,
    input  logic           i_cmd_pop,
    output md5_pkg::t_cmd  o_cmd
);
    import md5_pkg::*;

    // two-entry queue; unused mode codes are dropped here
    t_cmd r_q [2];
    logic r_rd;
    logic r_wr;
    logic [1:0] r_cnt;
    logic push;
    logic pop;
    t_cmd cmd_in;

    always_comb begin
        cmd_in.data = i_data_byte;
        cmd_in.has_byte = 1'b0;
        cmd_in.finish = 1'b0;
        unique case (i_mode)
            MODE_ABSORB:        cmd_in.has_byte = 1'b1;
            MODE_ABSORB_FINISH: begin
                cmd_in.has_byte = 1'b1;
                cmd_in.finish = 1'b1;
            end
            MODE_FINISH:        cmd_in.finish = 1'b1;
            default:            cmd_in.has_byte = 1'b0;
        endcase
    end

    assign o_stall = (r_cnt == 2'd2);
    assign pop = i_cmd_pop && (r_cnt != 2'd0);
    assign push = i_valid && !o_stall && (cmd_in.has_byte || cmd_in.finish);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop) r_rd <= !r_rd;
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
    end
endmodule

[design/md5_back.sv]
module md5_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  md5_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [31:0]    o_digest_word,
    output logic [1:0]     o_word_index,
    output logic           o_is_last
);
    import md5_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;  // write zeros / length bytes
    localparam logic [2:0] ST_PRE  = 3'd2;  // prime the word read
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_st;
    logic [5:0]  r_pos;
    logic [63:0] r_bits;
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_rnd;
    logic        r_fin;        // current padding and compression are the final ones
    logic        r_len;        // a length block follows this compression
    logic        r_byte_done;  // byte of an absorb-and-finish entry already taken
    logic [1:0]  r_oidx;
    logic        r_oval;
    logic        n_oval;
    logic [31:0] r_oword;

    // block buffer: 16 words, bytes gather in lane registers
    logic [7:0]  r_lane [3];
    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;
    logic [3:0]  raddr;
    logic [31:0] rdata;
    logic [7:0]  wbyte;
    logic        byte_wr;
    logic        absorb;
    logic        finish_take;
    logic        pad_wrap;
    logic        out_load;
    logic [5:0]  pos_nx;
    logic [5:0]  rnd_rd;
    logic [31:0] f, sum, rot;
    logic [4:0]  sh;

    md5_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // absorb-and-finish: the byte is taken first, the entry stays queued for the finish
    assign absorb = (r_st == ST_IDLE) && i_cmd_valid && i_cmd.has_byte && !r_byte_done;
    assign finish_take = (r_st == ST_IDLE) && i_cmd_valid && !absorb;
    assign o_cmd_pop = (absorb && !i_cmd.finish) || finish_take;

    assign pos_nx = 6'(r_pos + 6'd1);
    assign pad_wrap = (pos_nx == 6'd0) || (pos_nx > LEN_POS);

    always_comb begin
        byte_wr = absorb || finish_take || (r_st == ST_PAD);
        if (absorb) begin
            wbyte = i_cmd.data;
        end else if (finish_take) begin
            wbyte = PAD_BYTE;
        end else if (r_fin && r_pos[5:3] == 3'b111) begin
            wbyte = r_bits[{r_pos[2:0], 3'b000} +: 8];
        end else begin
            wbyte = 8'h00;
        end
    end

    // the word is written when its top byte arrives
    assign we = byte_wr && (r_pos[1:0] == 2'd3);
    assign waddr = r_pos[5:2];
    assign wdata = {wbyte, r_lane[2], r_lane[1], r_lane[0]};

    assign rnd_rd = (r_st == ST_PRE) ? 6'd0 : 6'(r_rnd + 6'd1);
    assign raddr = round_g(rnd_rd);

    always_comb begin
        unique case (r_rnd[5:4])
            2'd0: f = (r_b & r_c) | (~r_b & r_d);
            2'd1: f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f + round_k(r_rnd) + rdata;
        sh = round_s(r_rnd);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    assign out_load = (r_st == ST_OUT) && (!r_oval || !i_stall);
    assign n_oval = out_load || (r_oval && i_stall);

    always_ff @(posedge i_clk) begin
        if (byte_wr) begin
            case (r_pos[1:0])
                2'd0: r_lane[0] <= wbyte;
                2'd1: r_lane[1] <= wbyte;
                2'd2: r_lane[2] <= wbyte;
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_pos <= 6'd0;
            r_bits <= 64'd0;
            r_h[0] <= IV0; r_h[1] <= IV1; r_h[2] <= IV2; r_h[3] <= IV3;
            r_fin <= 1'b0;
            r_len <= 1'b0;
            r_byte_done <= 1'b0;
            r_oval <= 1'b0;
            r_oidx <= 2'd0;
            r_rnd <= 6'd0;
        end else begin
            r_oval <= n_oval;
            unique case (r_st)
                ST_IDLE: begin
                    if (absorb) begin
                        r_pos <= pos_nx;
                        r_bits <= r_bits + 64'd8;
                        r_byte_done <= i_cmd.finish;
                        if (pos_nx == 6'd0) r_st <= ST_PRE;
                    end else if (finish_take) begin
                        r_pos <= pos_nx;
                        r_byte_done <= 1'b0;
                        // pad byte past 55: this block ends without the length
                        r_fin <= !pad_wrap;
                        r_len <= pad_wrap;
                        r_st <= (pos_nx == 6'd0) ? ST_PRE : ST_PAD;
                    end
                end
                ST_PAD: begin
                    r_pos <= pos_nx;
                    if (pos_nx == 6'd0) r_st <= ST_PRE;
                end
                ST_PRE: begin
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                    r_rnd <= 6'd0;
                    r_st <= ST_RND;
                end
                ST_RND: begin
                    r_a <= r_d;
                    r_d <= r_c;
                    r_c <= r_b;
                    r_b <= r_b + rot;
                    r_rnd <= 6'(r_rnd + 6'd1);
                    if (r_rnd == 6'd63) r_st <= ST_ADD;
                end
                ST_ADD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    if (r_fin) begin
                        r_st <= ST_OUT;
                    end else if (r_len) begin
                        r_len <= 1'b0;
                        r_fin <= 1'b1;
                        r_st <= ST_PAD;
                    end else begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_oword <= r_h[r_oidx];
                        r_oidx <= 2'(r_oidx + 2'd1);
                        if (r_oidx == 2'd3) begin
                            r_st <= ST_IDLE;
                            r_h[0] <= IV0; r_h[1] <= IV1; r_h[2] <= IV2; r_h[3] <= IV3;
                            r_pos <= 6'd0;
                            r_bits <= 64'd0;
                            r_fin <= 1'b0;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_oval;
    assign o_digest_word = r_oword;
    assign o_word_index = 2'(r_oidx - 2'd1);
    assign o_is_last = (r_oidx == 2'd0);
endmodule

[design/md5_message_digest.sv]
// md5 message digest, one message byte per input transaction
//
// input channel: i_valid / o_stall with i_mode and i_data_byte. mode 0 absorbs a
// byte, mode 1 absorbs a byte and finishes, mode 2 finishes with no byte, mode 3
// is dropped. a two-entry queue sits between the input side and the hash engine.
// output channel: o_valid / i_stall carrying o_digest_word, o_word_index and
// o_is_last; four transactions per finished message, word 0 first.
// every 64th byte starts a compression (one load, 64 rounds one at a time on the
// shared round unit, one add); bytes wait in the queue while it runs. finish
// pads one byte a cycle up to the block end, runs one or two compressions, then
// shows the digest words one per cycle while i_stall is low.
// a stalled output holds its word; the engine waits while it hands out the
// digest, so the input queue keeps filling and then raises o_stall.
// synchronous reset loads the initial chaining value and clears the byte
// position and bit count; the block buffer needs no clearing.
module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_is_last
);
    import md5_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    md5_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_data_byte(i_data_byte),
        .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop), .o_cmd(cmd)
    );

    md5_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop),
        .i_cmd(cmd), .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index), .o_is_last(o_is_last)
    );

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_last == (o_word_index == 2'd3)))
        else $error("is_last disagrees with word index");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_word))
        else $error("stalled digest word changed");

    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");
endmodule
